// ===== hdl/cdq_pkg.sv =====
// Shared types, codes and defaults for the circular deque.
package cdq_pkg;

   localparam int DEPTH_DEF      = 128;
   localparam int DATA_WIDTH_DEF = 32;

   localparam int CAP_W    = 8;
   localparam int MODE_W   = 3;
   localparam int STATUS_W = 2;

   localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;

   localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_POP_REAR   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_QUERY      = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_DONE       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY  = 2'd2;

   // Controller to datapath commands.
   typedef struct packed {
      logic exec;
      logic rd;
      logic load;
   } cdq_cmd_type;

endpackage

// ===== hdl/cdq_req_if.sv =====
// Request channel: one deque operation and its value.
interface cdq_req_if
   import cdq_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) ();
   logic                  valid;
   logic                  ready;
   logic [MODE_W-1:0]     mode;
   logic [DATA_WIDTH-1:0] data_value;

   modport source (output valid, output mode, output data_value, input ready);
   modport sink   (input valid, input mode, input data_value, output ready);
endinterface

// ===== hdl/cdq_rsp_if.sv =====
// Response channel: status, end values and flags after an operation.
interface cdq_rsp_if
   import cdq_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) ();
   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [DATA_WIDTH-1:0] front_value;
   logic [DATA_WIDTH-1:0] rear_value;
   logic                  is_empty;
   logic                  is_full;

   modport source (output valid, output status, output front_value, output rear_value,
                   output is_empty, output is_full, input ready);
   modport sink   (input valid, input status, input front_value, input rear_value,
                   input is_empty, input is_full, output ready);
endinterface

// ===== hdl/circular_deque_core.sv =====
// A request is accepted in ST_IDLE, its slots are read in ST_READ and its result is
// registered in ST_LOAD; a new request is taken only after that load.
// A result still waiting holds the next one in its load step until it is taken.
// Reset (synchronous): deque empty, indices zero, capacity 128; slots are not cleared.
// A capacity write also empties the deque.
module circular_deque_core
   import cdq_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   cdq_req_if.sink          req_if,
   cdq_rsp_if.source        rsp_if,
   input  logic             csr_wr_en,
   input  logic [CAP_W-1:0] csr_wr_data
);

   cdq_cmd_type cmd;

   cdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd)
   );

   cdq_dp #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .mode        (req_if.mode),
      .data_value  (req_if.data_value),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .status      (rsp_if.status),
      .front_value (rsp_if.front_value),
      .rear_value  (rsp_if.rear_value),
      .is_empty    (rsp_if.is_empty),
      .is_full     (rsp_if.is_full)
   );

endmodule

// ===== hdl/cdq_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module cdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem[rd_addr_a];
         rd_data_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ===== hdl/cdq_ctrl.sv =====
// Controller: sequences accept, slot read and result load.
module cdq_ctrl
   import cdq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output cdq_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   always_comb begin
      cmd.exec = (state_ff == ST_IDLE) && req_valid;
      cmd.rd   = (state_ff == ST_READ);
      // load only once the previous result has left
      cmd.load = (state_ff == ST_LOAD) && (!rsp_valid_ff || rsp_ready);
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               state_ff <= ST_LOAD;
            end
            ST_LOAD: begin
               if (cmd.load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_exec_then_read: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> cmd.rd)
      else $error("read did not follow an accepted request");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.exec, cmd.rd, cmd.load}))
      else $error("more than one datapath command at once");
`endif

endmodule

// ===== hdl/cdq_dp.sv =====
// Datapath: capacity, head/tail indices, slot store and result registers.
module cdq_dp
   import cdq_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cdq_cmd_type           cmd,
   input  logic [MODE_W-1:0]     mode,
   input  logic [DATA_WIDTH-1:0] data_value,
   input  logic                  csr_wr_en,
   input  logic [CAP_W-1:0]      csr_wr_data,
   output logic [STATUS_W-1:0]   status,
   output logic [DATA_WIDTH-1:0] front_value,
   output logic [DATA_WIDTH-1:0] rear_value,
   output logic                  is_empty,
   output logic                  is_full
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CMP_W = (IDX_W + 1 > CAP_W) ? IDX_W + 1 : CAP_W;
   localparam logic [DATA_WIDTH-1:0] EMPTY_MARK = {DATA_WIDTH{1'b1}} >> 1;

   logic [CAP_W-1:0]    cap_ff, cap_in;
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [IDX_W-1:0]    tail_ff, tail_in;
   logic                empty_ff, empty_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   logic [STATUS_W-1:0]   status_out_ff;
   logic [DATA_WIDTH-1:0] front_out_ff;
   logic [DATA_WIDTH-1:0] rear_out_ff;
   logic                  empty_out_ff;
   logic                  full_out_ff;

   logic [CMP_W-1:0]      cap_eff;
   logic [CMP_W-1:0]      head_p1;
   logic [CMP_W-1:0]      tail_p1;
   logic [IDX_W-1:0]      head_inc, head_dec, tail_inc, tail_dec;
   logic                  full_now;
   logic                  is_push, is_pop;

   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [DATA_WIDTH-1:0] rd_data_a, rd_data_b;

   // Clamp the register to the range 1..DEPTH.
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CMP_W'(1);
      end else if (CMP_W'(cap_ff) > CMP_W'(DEPTH)) begin
         cap_eff = CMP_W'(DEPTH);
      end else begin
         cap_eff = CMP_W'(cap_ff);
      end
   end

   always_comb begin
      head_p1  = CMP_W'(head_ff) + CMP_W'(1);
      tail_p1  = CMP_W'(tail_ff) + CMP_W'(1);
      head_inc = (head_p1 >= cap_eff) ? '0 : head_p1[IDX_W-1:0];
      tail_inc = (tail_p1 >= cap_eff) ? '0 : tail_p1[IDX_W-1:0];
      head_dec = (head_ff == '0) ? IDX_W'(cap_eff - CMP_W'(1)) : head_ff - IDX_W'(1);
      tail_dec = (tail_ff == '0) ? IDX_W'(cap_eff - CMP_W'(1)) : tail_ff - IDX_W'(1);
      full_now = !empty_ff && (head_ff == tail_inc);
      is_push  = mode inside {MODE_PUSH_FRONT, MODE_PUSH_REAR};
      is_pop   = mode inside {MODE_POP_FRONT, MODE_POP_REAR};
   end

   always_comb begin
      cap_in    = cap_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      empty_in  = empty_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = '0;
      if (cmd.exec) begin
         status_in = STATUS_DONE;
         if (is_push) begin
            if (full_now) begin
               status_in = STATUS_PUSH_FULL;
            end else if (empty_ff) begin
               head_in  = '0;
               tail_in  = '0;
               empty_in = 1'b0;
               wr_en    = 1'b1;
               wr_addr  = '0;
            end else if (mode == MODE_PUSH_FRONT) begin
               head_in = head_dec;
               wr_en   = 1'b1;
               wr_addr = head_dec;
            end else begin
               tail_in = tail_inc;
               wr_en   = 1'b1;
               wr_addr = tail_inc;
            end
         end else if (is_pop) begin
            if (empty_ff) begin
               status_in = STATUS_POP_EMPTY;
            end else if (head_ff == tail_ff) begin
               // last entry gone: return to the empty layout
               head_in  = '0;
               tail_in  = '0;
               empty_in = 1'b1;
            end else if (mode == MODE_POP_FRONT) begin
               head_in = head_inc;
            end else begin
               tail_in = tail_dec;
            end
         end
      end
      // A capacity write empties the deque.
      if (csr_wr_en) begin
         cap_in   = csr_wr_data;
         head_in  = '0;
         tail_in  = '0;
         empty_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_RESET;
         head_ff  <= '0;
         tail_ff  <= '0;
         empty_ff <= 1'b1;
      end else begin
         cap_ff   <= cap_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         empty_ff <= empty_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      if (cmd.load) begin
         status_out_ff <= status_ff;
         front_out_ff  <= empty_ff ? EMPTY_MARK : rd_data_a;
         rear_out_ff   <= empty_ff ? EMPTY_MARK : rd_data_b;
         empty_out_ff  <= empty_ff;
         full_out_ff   <= full_now;
      end
   end

   cdq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (data_value),
      .rd_en     (cmd.rd),
      .rd_addr_a (head_ff),
      .rd_addr_b (tail_ff),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   assign status      = status_out_ff;
   assign front_value = front_out_ff;
   assign rear_value  = rear_out_ff;
   assign is_empty    = empty_out_ff;
   assign is_full     = full_out_ff;

`ifndef SYNTHESIS
   a_cfg_clears: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> (empty_ff && head_ff == '0 && tail_ff == '0))
      else $error("capacity write did not empty the deque");
   a_empty_layout: assert property (@(posedge clock) disable iff (reset)
      empty_ff |-> (head_ff == '0 && tail_ff == '0))
      else $error("empty deque with nonzero index");
   a_idx_in_cap: assert property (@(posedge clock) disable iff (reset)
      (CMP_W'(head_ff) < cap_eff) && (CMP_W'(tail_ff) < cap_eff))
      else $error("index outside the capacity in use");
`endif

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for circular_deque_core: directed corner cases, then random traffic.
`timescale 1ns / 1ps

module testbench
   import cdq_pkg::*;
();

   localparam int CLK_HALF      = 6;
   localparam int RESET_CYCLES  = 10;
   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT   = 400;
   localparam logic [31:0] EMPTY_MARK = 32'h7FFF_FFFF;
   localparam logic [31:0] INT_MIN    = 32'h8000_0000;
   localparam logic [MODE_W-1:0] MODE_UNUSED_LO = MODE_QUERY + 3'd1;
   localparam logic [MODE_W-1:0] MODE_UNUSED_HI = '1;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [31:0]         front_value;
      logic [31:0]         rear_value;
      logic                is_empty;
      logic                is_full;
   } deque_view_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_wr_en = 1'b0;
   logic [CAP_W-1:0] csr_wr_data = '0;

   cdq_req_if req_ch ();
   cdq_rsp_if rsp_ch ();

   circular_deque_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Mirror of the deque contents and its capacity register.
   logic [31:0]      mirror_slots [DEPTH_DEF];
   int unsigned      mirror_head;
   int unsigned      mirror_tail;
   bit               mirror_empty;
   logic [CAP_W-1:0] mirror_cap;

   deque_view_type pending_views [$];

   bit idle_on = 1'b1;
   int stall_left = 0;
   int idle_cycles = 0;
   int ops_sent = 0;
   int results_checked = 0;
   int cap_writes = 0;
   int err_count = 0;

   initial begin
      req_ch.valid      = 1'b0;
      req_ch.mode       = MODE_QUERY;
      req_ch.data_value = '0;
      rsp_ch.ready      = 1'b1;
   end

   always #CLK_HALF clock = ~clock;

   function automatic int unsigned effective_cap(input logic [CAP_W-1:0] value);
      if (value == 0) return 1;
      if (value > DEPTH_DEF) return DEPTH_DEF;
      return value;
   endfunction

   function automatic bit mirror_full(input int unsigned cap);
      int unsigned next_tail;
      next_tail = (mirror_tail + 1 >= cap) ? 0 : mirror_tail + 1;
      return !mirror_empty && mirror_head == next_tail;
   endfunction

   function automatic void mirror_clear();
      mirror_head  = 0;
      mirror_tail  = 0;
      mirror_empty = 1'b1;
   endfunction

   function automatic deque_view_type deque_apply(input logic [MODE_W-1:0] op,
                                                  input logic [31:0] value);
      deque_view_type view;
      int unsigned cap;
      cap = effective_cap(mirror_cap);
      view.status = STATUS_DONE;
      if (mirror_head >= cap) mirror_head = 0;
      if (mirror_tail >= cap) mirror_tail = 0;
      case (op)
         MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
            if (mirror_full(cap)) begin
               view.status = STATUS_PUSH_FULL;
            end else if (mirror_empty) begin
               mirror_head     = 0;
               mirror_tail     = 0;
               mirror_empty    = 1'b0;
               mirror_slots[0] = value;
            end else if (op == MODE_PUSH_FRONT) begin
               mirror_head = (mirror_head == 0) ? cap - 1 : mirror_head - 1;
               mirror_slots[mirror_head] = value;
            end else begin
               mirror_tail = (mirror_tail + 1 >= cap) ? 0 : mirror_tail + 1;
               mirror_slots[mirror_tail] = value;
            end
         end
         MODE_POP_FRONT, MODE_POP_REAR: begin
            if (mirror_empty) begin
               view.status = STATUS_POP_EMPTY;
            end else if (mirror_head == mirror_tail) begin
               mirror_clear();
            end else if (op == MODE_POP_FRONT) begin
               mirror_head = (mirror_head + 1 >= cap) ? 0 : mirror_head + 1;
            end else begin
               mirror_tail = (mirror_tail == 0) ? cap - 1 : mirror_tail - 1;
            end
         end
         default: ;
      endcase
      if (mirror_empty) begin
         view.front_value = EMPTY_MARK;
         view.rear_value  = EMPTY_MARK;
      end else begin
         view.front_value = mirror_slots[mirror_head];
         view.rear_value  = mirror_slots[mirror_tail];
      end
      view.is_empty = mirror_empty;
      view.is_full  = mirror_full(cap);
      return view;
   endfunction

   // Check results first, then predict from the request taken at this edge.
   always @(posedge clock) begin
      deque_view_type exp_view;
      if (reset) begin
         mirror_cap = CAP_RESET;
         mirror_clear();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_checked++;
            if (pending_views.size() == 0) begin
               err_count++;
               $error("result transfer with no pending expectation");
            end else begin
               exp_view = pending_views.pop_front();
               if (rsp_ch.status !== exp_view.status) begin
                  err_count++;
                  $error("status: expected %0d, actual %0d", exp_view.status, rsp_ch.status);
               end
               if (rsp_ch.front_value !== exp_view.front_value) begin
                  err_count++;
                  $error("front_value: expected %0d, actual %0d",
                         $signed(exp_view.front_value), $signed(rsp_ch.front_value));
               end
               if (rsp_ch.rear_value !== exp_view.rear_value) begin
                  err_count++;
                  $error("rear_value: expected %0d, actual %0d",
                         $signed(exp_view.rear_value), $signed(rsp_ch.rear_value));
               end
               if (rsp_ch.is_empty !== exp_view.is_empty) begin
                  err_count++;
                  $error("is_empty: expected %0d, actual %0d", exp_view.is_empty, rsp_ch.is_empty);
               end
               if (rsp_ch.is_full !== exp_view.is_full) begin
                  err_count++;
                  $error("is_full: expected %0d, actual %0d", exp_view.is_full, rsp_ch.is_full);
               end
            end
         end
         if (csr_wr_en) begin
            mirror_cap = csr_wr_data;
            mirror_clear();
         end
         if (req_ch.valid && req_ch.ready) begin
            pending_views.push_back(deque_apply(req_ch.mode, req_ch.data_value));
         end
      end
   end

   // Result side back-pressure in random bursts.
   always @(posedge clock) begin
      if (reset || !idle_on) stall_left = 0;
      else if (stall_left > 0) stall_left--;
      else if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 12);
      rsp_ch.ready <= (stall_left == 0);
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          csr_wr_en) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("testbench: timeout after %0d cycles without a transfer", idle_cycles);
            $display("testbench: done, errors");
            $finish;
         end
      end
   end

   task automatic send_op(input logic [MODE_W-1:0] op, input logic [31:0] value);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 12);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.mode       <= op;
      req_ch.data_value <= value;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      ops_sent++;
   endtask

   // Hold the sender until every pending result has been taken.
   task automatic wait_drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_views.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      wait_drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cap_writes++;
   endtask

   task automatic test_reset_state();
      send_op(MODE_QUERY, 32'h1234_5678);
      send_op(MODE_POP_FRONT, '0);
      send_op(MODE_POP_REAR, '1);
   endtask

   task automatic test_push_pop_ends();
      send_op(MODE_PUSH_FRONT, INT_MIN);
      send_op(MODE_PUSH_REAR, EMPTY_MARK);
      // head wraps below slot zero to the top of the capacity
      send_op(MODE_PUSH_FRONT, '1);
      send_op(MODE_PUSH_REAR, '0);
      send_op(MODE_QUERY, 32'hDEAD_BEEF);
      send_op(MODE_POP_FRONT, '0);
      send_op(MODE_POP_REAR, '0);
      send_op(MODE_POP_FRONT, '0);
      send_op(MODE_POP_REAR, '0);
      send_op(MODE_PUSH_REAR, 32'h0000_005A);
   endtask

   task automatic test_unused_modes();
      send_op(MODE_UNUSED_LO, '1);
      send_op(MODE_UNUSED_LO + 3'd1, INT_MIN);
      send_op(MODE_UNUSED_HI, '0);
   endtask

   task automatic test_capacity_extremes();
      write_capacity(8'd1);
      send_op(MODE_PUSH_FRONT, 32'h0F0F_0F0F);
      send_op(MODE_PUSH_REAR, 32'hF0F0_F0F0);
      send_op(MODE_POP_REAR, '0);
      // zero capacity behaves as one slot
      write_capacity(8'd0);
      send_op(MODE_PUSH_REAR, 32'hA5A5_A5A5);
      send_op(MODE_PUSH_FRONT, 32'h5A5A_5A5A);
      send_op(MODE_POP_FRONT, '0);
      send_op(MODE_POP_FRONT, '0);
   endtask

   // Alternate push-heavy and pop-heavy runs long enough to hit full and empty.
   task automatic run_traffic(input logic [CAP_W-1:0] cap_value, input int n_items);
      int unsigned eff;
      int run_left;
      int r;
      bit push_bias;
      bit is_push;
      logic [MODE_W-1:0] op;
      logic [31:0] value;
      write_capacity(cap_value);
      eff = effective_cap(cap_value);
      push_bias = 1'b1;
      run_left = $urandom_range(eff, 2 * eff + 4);
      for (int i = 0; i < n_items; i++) begin
         if (i == n_items / 2) wait_drain();
         r = $urandom_range(0, 99);
         if (r < 4) begin
            op = MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
         end else if (r < 10) begin
            op = MODE_QUERY;
         end else begin
            is_push = push_bias ? ($urandom_range(0, 99) < 85) : ($urandom_range(0, 99) < 15);
            if (is_push) op = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_REAR;
            else op = $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_REAR;
         end
         value = $urandom;
         if ($urandom_range(0, 15) == 0) begin
            case ($urandom_range(0, 3))
               0: value = INT_MIN;
               1: value = EMPTY_MARK;
               2: value = '1;
               default: value = '0;
            endcase
         end
         send_op(op, value);
         run_left--;
         if (run_left <= 0) begin
            push_bias = !push_bias;
            run_left  = $urandom_range(eff, 2 * eff + 4);
         end
      end
   endtask

   task automatic test_random_traffic();
      run_traffic(8'd3, 90);
      run_traffic(8'd1, 40);
      run_traffic(8'd255, 280);
      run_traffic(8'd5, 90);
      run_traffic(8'd0, 40);
      run_traffic(8'd2, 60);
      run_traffic(8'd17, 80);
   endtask

   task automatic test_full_rate();
      wait_drain();
      idle_on = 1'b0;
      run_traffic(8'd128, 250);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_push_pop_ends();
      test_unused_modes();
      test_capacity_extremes();
      test_random_traffic();
      test_full_rate();
      wait_drain();
      $display("testbench: %0d operations sent, %0d results checked, %0d capacity writes",
               ops_sent, results_checked, cap_writes);
      $display("testbench: capacities 0 to 255 with wrap, full, empty and unused modes");
      if (err_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
